/* sv/trw_pkg.sv */
// ----------------------------------------------------------------------------
// trw_pkg
// Shared types and constants of the trace ring writer: request and response
// payloads, command and status codes, header field positions, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package trw_pkg;

   // ring size default (log2 of the word count)
   localparam int RING_WORDS_LOG2_DEFAULT = 12;

   // header layout
   localparam int LEN_SHIFT    = 54;
   localparam int USER_SHIFT   = 53;
   localparam int TYPE_SHIFT   = 49;
   localparam int ID_SHIFT     = 36;
   localparam int HDR_TS_WORDS = 2;
   localparam int LEN_WIDTH    = 10;

   // largest payload whose total length still fits the length field
   localparam logic [9:0] MAX_PAYLOAD = 10'd1021;

   // request command codes
   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_PAYLOAD = 2'd1;
   localparam logic [1:0] CMD_READ    = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_IGNORED = 2'd1;
   localparam logic [1:0] STATUS_SEQ_ERR = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        user_event;
      logic [3:0]  event_type;
      logic [12:0] trace_id;
      logic [9:0]  payload_length;
      logic [63:0] stamp;
      logic [63:0] data_word;
      logic [11:0] read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] head_position;
      logic [63:0] tail_position;
      logic [63:0] read_word;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       latch;       // capture the accepted request
      logic       plan;        // compute pad and space needed for a start
      logic       rd_head;     // ring read address follows the head
      logic       evict_step;  // retire the message at the head
      logic       wr_pad;      // write the padding header
      logic       wr_hdr;      // write the message header
      logic       wr_ts;       // write the timestamp and open the event
      logic       wr_payload;  // write one payload word
      logic       load_out;    // load the response register
      logic [1:0] status;      // status carried into the response
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       capture_en;
      logic       event_open;
      logic       payload_open;
      logic       plen_bad;
      logic       pad_needed;
      logic       evict_more;
      logic       len_zero;
      logic       out_free;
   } dp_status_type;

endpackage

/* sv/trw_datapath.sv */
// ----------------------------------------------------------------------------
// trw_datapath
// Ring memory, head/tail counters, write pointer, open event bookkeeping,
// eviction arithmetic and the response register.
// ----------------------------------------------------------------------------
module trw_datapath #(
   parameter int RING_WORDS_LOG2 = trw_pkg::RING_WORDS_LOG2_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  trw_pkg::req_type       req_payload,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data,
   input  trw_pkg::ctrl_cmd_type  cmd,
   output trw_pkg::dp_status_type stat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output trw_pkg::rsp_type       rsp_payload
);

   localparam int L = RING_WORDS_LOG2;
   localparam int RING_WORDS = 1 << L;
   localparam logic [L:0]   RING_W = {1'b1, {L{1'b0}}};
   localparam logic [L+1:0] RING_G = {2'b01, {L{1'b0}}};

   // ring storage
   logic [63:0] ring_mem [RING_WORDS];
   logic [63:0] rdata_ff;
   logic        mem_we;
   logic [L-1:0] mem_waddr;
   logic [L-1:0] mem_raddr;
   logic [63:0] mem_wdata;

   // state
   trw_pkg::req_type item_ff;
   logic        cap_ff, cap_in;
   logic [63:0] head_ff, head_in;
   logic [63:0] tail_ff, tail_in;
   logic [L-1:0] wr_off_ff, wr_off_in;
   logic [9:0]  left_ff, left_in;
   logic [9:0]  pending_ff, pending_in;
   logic        open_ff, open_in;
   logic [63:0] need_ff;
   logic [9:0]  pad_ff;
   logic [9:0]  total_ff;
   logic [L+1:0] guard_ff, guard_in;
   trw_pkg::rsp_type rsp_ff;
   logic        rsp_valid_ff;

   // start planning
   logic [L-1:0] tail_off;
   logic [L:0]   room;
   logic [9:0]   total;
   logic [9:0]   pad;
   logic [10:0]  extra;
   logic [63:0]  span;
   logic [9:0]   head_len;
   logic [63:0]  hdr_word;
   logic [63:0]  read_word;

   assign tail_off = tail_ff[L-1:0];
   assign room     = RING_W - {1'b0, tail_off};
   assign total    = item_ff.payload_length + 10'(trw_pkg::HDR_TS_WORDS);
   assign pad      = (room < {{(L-9){1'b0}}, total}) ? room[9:0] : 10'd0;
   assign extra    = {1'b0, total} + {1'b0, pad};

   // space check and head header length
   assign span     = need_ff - head_ff;
   assign head_len = rdata_ff[63:trw_pkg::LEN_SHIFT];

   assign hdr_word = (64'(total_ff) << trw_pkg::LEN_SHIFT)
                   | (64'(item_ff.user_event) << trw_pkg::USER_SHIFT)
                   | (64'(item_ff.event_type) << trw_pkg::TYPE_SHIFT)
                   | (64'(item_ff.trace_id) << trw_pkg::ID_SHIFT);

   // status toward the controller
   always_comb begin
      stat.cmd          = item_ff.cmd;
      stat.capture_en   = cap_ff;
      stat.event_open   = open_ff;
      stat.payload_open = open_ff && (left_ff != 10'd0);
      stat.plen_bad     = item_ff.payload_length > trw_pkg::MAX_PAYLOAD;
      stat.pad_needed   = pad_ff != 10'd0;
      stat.evict_more   = (span[63:L] != '0) && (guard_ff <= RING_G);
      stat.len_zero     = head_len == 10'd0;
      stat.out_free     = !rsp_valid_ff || rsp_ready;
   end

   // ring write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wr_off_ff;
      mem_wdata = item_ff.data_word;
      priority if (cmd.wr_pad) begin
         mem_we    = 1'b1;
         mem_wdata = 64'(pad_ff) << trw_pkg::LEN_SHIFT;
      end else if (cmd.wr_hdr) begin
         mem_we    = 1'b1;
         mem_wdata = hdr_word;
      end else if (cmd.wr_ts) begin
         mem_we    = 1'b1;
         mem_wdata = item_ff.stamp;
      end else if (cmd.wr_payload) begin
         mem_we    = 1'b1;
      end
   end

   assign mem_raddr = cmd.rd_head ? head_ff[L-1:0] : L'(item_ff.read_index);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= ring_mem[mem_raddr];
   end

   // next state of the bookkeeping registers
   always_comb begin
      cap_in     = csr_wr_en ? csr_wr_data : cap_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      wr_off_in  = wr_off_ff;
      left_in    = left_ff;
      pending_in = pending_ff;
      open_in    = open_ff;
      guard_in   = guard_ff;
      priority if (cmd.plan) begin
         wr_off_in = tail_off;
         guard_in  = '0;
      end else if (cmd.evict_step) begin
         if (head_len == 10'd0) begin
            head_in = tail_ff;
         end else begin
            head_in  = head_ff + 64'(head_len);
            guard_in = guard_ff + (L+2)'(1);
         end
      end else if (cmd.wr_pad) begin
         tail_in   = tail_ff + 64'(pad_ff);
         wr_off_in = '0;
      end else if (cmd.wr_hdr) begin
         wr_off_in = wr_off_ff + L'(1);
      end else if (cmd.wr_ts) begin
         wr_off_in  = wr_off_ff + L'(1);
         pending_in = total_ff;
         left_in    = item_ff.payload_length;
         open_in    = 1'b1;
         if (item_ff.payload_length == 10'd0) begin
            tail_in = tail_ff + 64'(total_ff);
            open_in = 1'b0;
         end
      end else if (cmd.wr_payload) begin
         wr_off_in = wr_off_ff + L'(1);
         left_in   = left_ff - 10'd1;
         if (left_ff == 10'd1) begin
            tail_in = tail_ff + 64'(pending_ff);
            open_in = 1'b0;
            left_in = 10'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= 1'b0;
         head_ff    <= '0;
         tail_ff    <= '0;
         wr_off_ff  <= '0;
         left_ff    <= '0;
         pending_ff <= '0;
         open_ff    <= 1'b0;
         guard_ff   <= '0;
      end else begin
         cap_ff     <= cap_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         wr_off_ff  <= wr_off_in;
         left_ff    <= left_in;
         pending_ff <= pending_in;
         open_ff    <= open_in;
         guard_ff   <= guard_in;
      end
   end

   // request capture and start plan
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         item_ff <= req_payload;
      end
      if (cmd.plan) begin
         need_ff  <= tail_ff + 64'(extra);
         pad_ff   <= pad;
         total_ff <= total;
      end
   end

   // response register
   assign read_word = (item_ff.cmd == trw_pkg::CMD_READ && cmd.status == trw_pkg::STATUS_OK)
                    ? rdata_ff : 64'd0;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.status        <= cmd.status;
         rsp_ff.head_position <= head_ff;
         rsp_ff.tail_position <= tail_ff;
         rsp_ff.read_word     <= read_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* sv/trw_ctrl.sv */
// ----------------------------------------------------------------------------
// trw_ctrl
// Sequencer of the trace ring writer: decodes each request, walks old
// headers for eviction, steps the header writes and hands off the response.
// ----------------------------------------------------------------------------
module trw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  trw_pkg::dp_status_type stat,
   output trw_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b00000001,
      ST_DECODE    = 8'b00000010,
      ST_EVICT_CHK = 8'b00000100,
      ST_EVICT_UPD = 8'b00001000,
      ST_WR_PAD    = 8'b00010000,
      ST_WR_HDR    = 8'b00100000,
      ST_WR_TS     = 8'b01000000,
      ST_FINISH    = 8'b10000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      cmd        = '0;
      cmd.status = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in  = ST_FINISH;
            status_in = trw_pkg::STATUS_OK;
            unique case (stat.cmd)
               trw_pkg::CMD_START: begin
                  if (!stat.capture_en) begin
                     status_in = trw_pkg::STATUS_IGNORED;
                  end else if (stat.event_open || stat.plen_bad) begin
                     status_in = trw_pkg::STATUS_SEQ_ERR;
                  end else begin
                     cmd.plan = 1'b1;
                     state_in = ST_EVICT_CHK;
                  end
               end
               trw_pkg::CMD_PAYLOAD: begin
                  if (!stat.capture_en) begin
                     status_in = trw_pkg::STATUS_IGNORED;
                  end else if (!stat.payload_open) begin
                     status_in = trw_pkg::STATUS_SEQ_ERR;
                  end else begin
                     cmd.wr_payload = 1'b1;
                  end
               end
               trw_pkg::CMD_READ: begin
                  // read address follows the request, data lands for FINISH
               end
               default: begin
                  status_in = trw_pkg::STATUS_SEQ_ERR;
               end
            endcase
         end
         ST_EVICT_CHK: begin
            // head header read is issued here, examined next cycle
            cmd.rd_head = 1'b1;
            if (stat.evict_more) begin
               state_in = ST_EVICT_UPD;
            end else if (stat.pad_needed) begin
               state_in = ST_WR_PAD;
            end else begin
               state_in = ST_WR_HDR;
            end
         end
         ST_EVICT_UPD: begin
            cmd.evict_step = 1'b1;
            if (!stat.len_zero) begin
               state_in = ST_EVICT_CHK;
            end else if (stat.pad_needed) begin
               state_in = ST_WR_PAD;
            end else begin
               state_in = ST_WR_HDR;
            end
         end
         ST_WR_PAD: begin
            cmd.wr_pad = 1'b1;
            state_in   = ST_WR_HDR;
         end
         ST_WR_HDR: begin
            cmd.wr_hdr = 1'b1;
            state_in   = ST_WR_TS;
         end
         ST_WR_TS: begin
            cmd.wr_ts = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         status_ff <= trw_pkg::STATUS_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

endmodule

/* sv/trace_ring_writer_top.sv */
// Sequencing: one request in flight; a start also walks and retires old messages and
//   writes a padding header when needed before its header and timestamp.
//   The next transfer is taken in the cycle after the response is loaded.
// Reset (synchronous): counters, open event and capture enable clear at once;
//   ring contents are left undefined, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// trace_ring_writer_top
// Appends trace events to an overwriting ring of 64-bit words and answers
// ring reads with the current head and tail positions.
// ----------------------------------------------------------------------------
module trace_ring_writer_top #(
   parameter int RING_WORDS_LOG2 = trw_pkg::RING_WORDS_LOG2_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  trw_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output trw_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   trw_pkg::ctrl_cmd_type  cmd;
   trw_pkg::dp_status_type stat;

   // sequencer
   trw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // ring and counters
   trw_datapath #(
      .RING_WORDS_LOG2 (RING_WORDS_LOG2)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* sv/trw_checker.sv */
// ----------------------------------------------------------------------------
// trw_checker
// Port-level checks of the trace ring writer: response hold, ring occupancy,
// monotonic positions and read data only on good reads.
// ----------------------------------------------------------------------------
module trw_checker #(
   parameter int RING_WORDS_LOG2 = trw_pkg::RING_WORDS_LOG2_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input trw_pkg::rsp_type rsp_payload
);

   localparam logic [63:0] RING_WORDS = 64'd1 << RING_WORDS_LOG2;

   // positions of the last response taken
   logic        seen_ff;
   logic [63:0] last_head_ff;
   logic [63:0] last_tail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         last_head_ff <= rsp_payload.head_position;
         last_tail_ff <= rsp_payload.tail_position;
      end
   end

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // nothing valid right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // kept messages never exceed the ring
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.tail_position - rsp_payload.head_position) <= RING_WORDS)
      else $error("ring occupancy above ring size");

   // head and tail only move forward
   a_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ff |->
         rsp_payload.tail_position >= last_tail_ff &&
         rsp_payload.head_position >= last_head_ff)
      else $error("position moved backward");

   // read data only with ok status
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != trw_pkg::STATUS_OK |-> rsp_payload.read_word == 64'd0)
      else $error("read data on a failed command");

endmodule

bind trace_ring_writer_top trw_checker #(
   .RING_WORDS_LOG2 (RING_WORDS_LOG2)
) u_trw_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

/* sim/trace_ring_writer_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_ring_writer_top_test
// Self-checking bench for the trace ring writer. Trace commands (starts,
// payload words, ring reads, malformed commands) are queued per phase and
// sent over the request channel. The capture enable is changed between
// phases. Every accepted command is run through a local ring model. Each
// response is checked field by field against the oldest outstanding reply.
// ----------------------------------------------------------------------------
module trace_ring_writer_top_test;

   localparam int RING_BITS = trw_pkg::RING_WORDS_LOG2_DEFAULT;
   localparam int RING_WORDS = 1 << RING_BITS;
   // command code with no function in the block
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   trw_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_ready;
   trw_pkg::rsp_type rsp_payload;
   logic             csr_wr_en;
   logic             csr_wr_data;

   trace_ring_writer_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ring model state
   bit [63:0]          ring_words [RING_WORDS];
   bit                 ring_filled [RING_WORDS];
   logic [RING_BITS-1:0] fill_ptr;
   logic [RING_BITS-1:0] last_put;
   logic [63:0]        oldest_pos;
   logic [63:0]        commit_pos;
   int                 words_owed;
   int                 msg_len;
   bit                 msg_open;
   bit                 capture_on;

   // traffic
   trw_pkg::req_type trace_cmds_q[$];
   trw_pkg::rsp_type ring_replies_q[$];
   int      mismatches;
   int      rsp_count;
   bit      req_done;
   bit      rsp_done;
   int      req_gap;
   int      req_burst;
   int      rsp_stall;
   int      rsp_burst;
   int      rsp_hold;

   // sequence bookkeeping used while queuing commands
   bit gen_capture;
   bit gen_open;
   bit gen_wrote;
   int gen_owed;
   int queued;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("trace_ring_writer_top_test: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // ring model
   // ------------------------------------------------------------------------
   task automatic ring_put(input logic [63:0] w);
      ring_words[fill_ptr] = w;
      ring_filled[fill_ptr] = 1'b1;
      last_put = fill_ptr;
      fill_ptr = fill_ptr + 1'b1;
   endtask

   task automatic close_msg();
      commit_pos += 64'(msg_len);
      msg_open = 1'b0;
      words_owed = 0;
   endtask

   task automatic ring_advance(input trw_pkg::req_type r, output trw_pkg::rsp_type o);
      logic [63:0] tot;
      logic [63:0] room;
      logic [63:0] pad;
      logic [63:0] need;
      logic [9:0]  hdr_len;
      int          guard;
      o = '0;
      o.status = trw_pkg::STATUS_OK;
      case (r.cmd)
         trw_pkg::CMD_START: begin
            if (!capture_on) begin
               o.status = trw_pkg::STATUS_IGNORED;
            end else if (msg_open || r.payload_length > trw_pkg::MAX_PAYLOAD) begin
               o.status = trw_pkg::STATUS_SEQ_ERR;
            end else begin
               tot = 64'(r.payload_length) + 64'(trw_pkg::HDR_TS_WORDS);
               room = 64'(RING_WORDS) - 64'(commit_pos[RING_BITS-1:0]);
               pad = (room < tot) ? room : 64'd0;
               need = commit_pos + tot + pad;
               // retire oldest messages until the new one fits
               guard = 0;
               while (need - oldest_pos >= 64'(RING_WORDS) && guard <= RING_WORDS) begin
                  hdr_len = ring_words[oldest_pos[RING_BITS-1:0]][63:54];
                  if (hdr_len == 10'd0) begin
                     oldest_pos = commit_pos;
                     break;
                  end
                  oldest_pos += 64'(hdr_len);
                  guard++;
               end
               fill_ptr = commit_pos[RING_BITS-1:0];
               // padding header covers the rest of the ring
               if (pad != 64'd0) begin
                  ring_put(pad << trw_pkg::LEN_SHIFT);
                  commit_pos += pad;
                  fill_ptr = '0;
               end
               ring_put((tot << trw_pkg::LEN_SHIFT) |
                        (64'(r.user_event) << trw_pkg::USER_SHIFT) |
                        (64'(r.event_type) << trw_pkg::TYPE_SHIFT) |
                        (64'(r.trace_id) << trw_pkg::ID_SHIFT));
               ring_put(r.stamp);
               msg_len = int'(tot);
               words_owed = int'(r.payload_length);
               msg_open = 1'b1;
               if (words_owed == 0) close_msg();
            end
         end
         trw_pkg::CMD_PAYLOAD: begin
            if (!capture_on) begin
               o.status = trw_pkg::STATUS_IGNORED;
            end else if (!msg_open || words_owed == 0) begin
               o.status = trw_pkg::STATUS_SEQ_ERR;
            end else begin
               ring_put(r.data_word);
               words_owed--;
               if (words_owed == 0) close_msg();
            end
         end
         trw_pkg::CMD_READ: begin
            o.read_word = ring_words[r.read_index];
         end
         default: begin
            o.status = trw_pkg::STATUS_SEQ_ERR;
         end
      endcase
      o.head_position = oldest_pos;
      o.tail_position = commit_pos;
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic int pick_wait(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         burst = $urandom_range(16, 64);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   function automatic trw_pkg::req_type rand_req(input logic [1:0] code);
      trw_pkg::req_type r;
      r.cmd = code;
      r.user_event = 1'($urandom);
      r.event_type = 4'($urandom);
      r.trace_id = 13'($urandom);
      r.payload_length = 10'($urandom);
      r.stamp = {$urandom, $urandom};
      r.data_word = {$urandom, $urandom};
      r.read_index = 12'($urandom);
      return r;
   endfunction

   // queue one command and track whether a message is open
   task automatic queue_req(input trw_pkg::req_type r);
      trace_cmds_q.push_back(r);
      queued++;
      if (gen_capture) begin
         if (r.cmd == trw_pkg::CMD_START && !gen_open &&
             r.payload_length <= trw_pkg::MAX_PAYLOAD) begin
            gen_wrote = 1'b1;
            gen_owed = int'(r.payload_length);
            gen_open = (gen_owed != 0);
         end else if (r.cmd == trw_pkg::CMD_PAYLOAD && gen_open) begin
            gen_owed--;
            gen_open = (gen_owed != 0);
         end
      end
   endtask

   task automatic queue_start(input int plen);
      trw_pkg::req_type r;
      r = rand_req(trw_pkg::CMD_START);
      r.payload_length = 10'(plen);
      queue_req(r);
   endtask

   task automatic queue_payload();
      queue_req(rand_req(trw_pkg::CMD_PAYLOAD));
   endtask

   // reads only once the ring holds something
   task automatic queue_read();
      if (gen_wrote) queue_req(rand_req(trw_pkg::CMD_READ));
   endtask

   task automatic queue_noise();
      case ($urandom_range(0, 2))
         0: queue_req(rand_req(CMD_UNUSED));
         1: queue_start($urandom_range(int'(trw_pkg::MAX_PAYLOAD) + 1, 1023));
         default: begin
            // start on an open message, or a stray payload word
            if (gen_open) queue_start($urandom_range(0, 1023));
            else queue_payload();
         end
      endcase
   endtask

   function automatic int draw_plen();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 85) return $urandom_range(1, 3);
      if (k < 98) return $urandom_range(4, 16);
      return $urandom_range(17, 120);
   endfunction

   // one well-formed message with reads and noise mixed in
   task automatic queue_message();
      if ($urandom_range(0, 11) == 0) queue_noise();
      if ($urandom_range(0, 9) == 0) queue_read();
      queue_start(draw_plen());
      while (gen_open) begin
         if ($urandom_range(0, 15) == 0) queue_read();
         if ($urandom_range(0, 24) == 0) queue_noise();
         queue_payload();
      end
   endtask

   task automatic set_capture(input bit en);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= en;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      capture_on = en;
      gen_capture = en;
   endtask

   // wait until every queued command has been answered
   task automatic drain();
      @(posedge clock);
      while (trace_cmds_q.size() != 0 || req_valid || ring_replies_q.size() != 0)
         @(posedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic flag_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s: expected %0h, got %0h", name, want, got);
      end
   endtask

   // ------------------------------------------------------------------------
   // request driver: one command offered at a time, random gaps between
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      trw_pkg::req_type nxt;
      if (!reset) begin
         if (!req_valid || req_done) begin
            if (req_valid) req_gap = pick_wait(req_burst);
            if (req_gap == 0 && trace_cmds_q.size() != 0) begin
               nxt = trace_cmds_q.pop_front();
               // steer reads away from ring words never written
               if (nxt.cmd == trw_pkg::CMD_READ && !ring_filled[nxt.read_index])
                  nxt.read_index = last_put;
               req_payload <= nxt;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
               if (req_gap > 0) req_gap--;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // response receiver: random stalls, one long hold-off to back up input
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_done) begin
            rsp_stall = pick_wait(rsp_burst);
            if (rsp_count == 300) rsp_hold = 400;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // transfer monitor: model each accepted command, check each response
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      trw_pkg::rsp_type want;
      if (reset) begin
         req_done <= 1'b0;
         rsp_done <= 1'b0;
      end else begin
         req_done <= req_valid && req_ready;
         rsp_done <= rsp_valid && rsp_ready;
         if (req_valid && req_ready) begin
            ring_advance(req_payload, want);
            ring_replies_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (ring_replies_q.size() == 0) begin
               mismatches++;
               $error("response transfer with no command outstanding");
            end else begin
               want = ring_replies_q.pop_front();
               flag_field("status", 64'(want.status), 64'(rsp_payload.status));
               flag_field("head_position", want.head_position, rsp_payload.head_position);
               flag_field("tail_position", want.tail_position, rsp_payload.tail_position);
               flag_field("read_word", want.read_word, rsp_payload.read_word);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      trw_pkg::req_type r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      fill_ptr = '0;
      last_put = '0;
      oldest_pos = '0;
      commit_pos = '0;
      words_owed = 0;
      msg_len = 0;
      msg_open = 1'b0;
      capture_on = 1'b0;
      mismatches = 0;
      rsp_count = 0;
      req_gap = 0;
      req_burst = 0;
      rsp_stall = 0;
      rsp_burst = 0;
      rsp_hold = 0;
      gen_capture = 1'b0;
      gen_open = 1'b0;
      gen_wrote = 1'b0;
      gen_owed = 0;
      queued = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // capture off: start and payload are ignored
      set_capture(1'b0);
      queue_start(4);
      queue_payload();
      queue_req(rand_req(CMD_UNUSED));
      drain();

      set_capture(1'b1);
      // header fields at their extremes
      r = rand_req(trw_pkg::CMD_START);
      r.payload_length = '0;
      r.user_event = 1'b1;
      r.event_type = '1;
      r.trace_id = '1;
      r.stamp = '1;
      queue_req(r);
      r = rand_req(trw_pkg::CMD_START);
      r.payload_length = '0;
      r.user_event = 1'b0;
      r.event_type = '0;
      r.trace_id = '0;
      r.stamp = '0;
      queue_req(r);
      r = rand_req(trw_pkg::CMD_READ);
      r.read_index = '0;
      queue_req(r);
      // payload with nothing open, lengths past the limit
      queue_payload();
      queue_start(int'(trw_pkg::MAX_PAYLOAD) + 1);
      queue_start(1023);
      // short message with a start inside it and a stray word after it
      queue_start(2);
      r = rand_req(trw_pkg::CMD_PAYLOAD);
      r.data_word = '1;
      queue_req(r);
      queue_start(0);
      r = rand_req(trw_pkg::CMD_PAYLOAD);
      r.data_word = '0;
      queue_req(r);
      queue_payload();
      queue_req(rand_req(CMD_UNUSED));
      r = rand_req(trw_pkg::CMD_READ);
      r.read_index = '1;
      queue_req(r);
      // longest message
      queue_start(int'(trw_pkg::MAX_PAYLOAD));
      while (gen_open) begin
         if ($urandom_range(0, 63) == 0) queue_read();
         queue_payload();
      end

      // random traffic, leaving a message open at the end
      queued = 0;
      while (queued < 350) queue_message();
      queue_start(12);
      repeat (4) queue_payload();
      drain();

      // capture paused while a message is open
      set_capture(1'b0);
      repeat (120) begin
         case ($urandom_range(0, 3))
            0: queue_start($urandom_range(0, 1023));
            1: queue_payload();
            2: queue_read();
            default: queue_req(rand_req(CMD_UNUSED));
         endcase
      end
      drain();

      // capture resumed: the open message is still open
      set_capture(1'b1);
      queue_start(3);
      while (gen_open) queue_payload();
      queued = 0;
      while (queued < 350) queue_message();
      drain();

      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("trace_ring_writer_top_test: PASS");
      end else begin
         $display("trace_ring_writer_top_test: FAIL");
      end
      $finish;
   end

endmodule
